// ===== src/vq_lloyd_codebook_trainer_macros.svh =====
// ----------------------------------------------------------------------------
// vq_lloyd_codebook_trainer_macros
// Assertion macros used by the port-level checker file.
// ----------------------------------------------------------------------------
`ifndef VQ_LLOYD_CODEBOOK_TRAINER_MACROS_SVH
`define VQ_LLOYD_CODEBOOK_TRAINER_MACROS_SVH

// same-cycle implication
`define VQLCT_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("vqlct check failed");

// next-cycle implication
`define VQLCT_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("vqlct check failed");

`endif

// ===== src/vqlct_pkg.sv =====
// ----------------------------------------------------------------------------
// vqlct_pkg
// Types and fixed constants of the Lloyd codebook trainer.
// ----------------------------------------------------------------------------
`default_nettype none

package vqlct_pkg;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_VECTOR = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_UPDATE = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT,
        ST_TR_CNT,
        ST_TR_CHK,
        ST_TR_RD,
        ST_TR_WR,
        ST_UPD_CNT,
        ST_UPD_CHK,
        ST_UPD_RD,
        ST_UPD_LD,
        ST_UPD_DIV,
        ST_UPD_WR,
        ST_UPD_NEXT,
        ST_UPD_DONE
    } t_state;

    localparam logic CFG_VECTOR_DIM    = 1'b0;
    localparam logic CFG_CODEBOOK_SIZE = 1'b1;

    localparam logic KIND_SEARCH = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    localparam int unsigned ERR_W   = 36;
    localparam int unsigned TOT_W   = 48;
    localparam int unsigned SUM_W   = 40;
    localparam int unsigned CNT_W   = 24;
    localparam int unsigned SQ_IN_W = 18;   // |diff| at or above 2^18 saturates
    localparam int unsigned ONE_SQ_SHIFT = 24;
    localparam int unsigned DVD_W   = SUM_W + 1;
    localparam logic [5:0]  DIV_LAST = 6'(DVD_W - 1);

    localparam logic [ERR_W-1:0] ERR_MAX   = '1;
    localparam logic [TOT_W-1:0] TOT_MAX   = '1;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== src/vq_lloyd_codebook_trainer.sv =====
// ----------------------------------------------------------------------------
// vq_lloyd_codebook_trainer
// Full-search Lloyd VQ step engine, Q4.12 samples, codebook and centroid
// accumulators held in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
//  Input items (valid/ready) carry an op. Write ops load one codebook word,
//  vector ops buffer one element. The last element of a vector starts a
//  search that streams one codebook word per cycle through a four-stage
//  subtract/square/accumulate pipe, fed by the single codebook RAM read port.
//  A search result item goes to the output register; with train set the
//  winner's count and sums are then updated, unless its count is saturated.
//  Update walks every entry in use and, through a bit-serial divider,
//  rewrites each element of the entries with a nonzero count, then emits
//  one update item.
//  Clear and reset sweep the sums and counts RAMs, one word per cycle, over
//  MAX_ENTRIES*MAX_DIM words (4096 by default); no item is taken meanwhile,
//  configuration writes are.
//  Output stall: an item waits in the output register; items are still taken
//  until the next result is ready, which then waits for it with no item taken.
// ----------------------------------------------------------------------------
`default_nettype none

module vq_lloyd_codebook_trainer #(
    parameter int MAX_DIM     = 16,
    parameter int MAX_ENTRIES = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wen,
    input  wire logic                          i_cfg_index,
    input  wire logic [8:0]                    i_cfg_wdata,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_op,
    input  wire logic [7:0]                    i_entry,
    input  wire logic [3:0]                    i_element,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_value,
    input  wire logic                          i_train,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_result_kind,
    output logic [7:0]                         o_best_index,
    output logic [vqlct_pkg::ERR_W-1:0]        o_best_error,
    output logic [vqlct_pkg::TOT_W-1:0]        o_total_error,
    output logic [1:0]                         o_outlier_level
);
    import vqlct_pkg::*;

    localparam int NWORDS = MAX_ENTRIES * MAX_DIM;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int EW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int DW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DCW    = $clog2(MAX_DIM + 1);
    localparam int SCW    = $clog2(MAX_ENTRIES + 1);
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam logic [DVD_W-1:0] Q_POS_MAX = DVD_W'((64'd1 << (SAMPLE_BITS-1)) - 64'd1);
    localparam logic [DVD_W-1:0] Q_NEG_MAX = DVD_W'(64'd1 << (SAMPLE_BITS-1));

    // state and config
    t_state r_state, n_state;
    logic [4:0]    r_vdim;
    logic [8:0]    r_csize;
    logic [AW-1:0] r_clr;
    logic [DW-1:0] r_pos;
    logic [TOT_W-1:0] r_total;
    logic          r_train;

    // memories
    logic signed [SAMPLE_BITS-1:0] r_cb_mem  [NWORDS];
    logic [SUM_W-1:0]              r_sum_mem [NWORDS];
    logic [CNT_W-1:0]              r_cnt_mem [MAX_ENTRIES];
    logic signed [SAMPLE_BITS-1:0] r_cb_q;
    logic [SUM_W-1:0]              r_sum_q;
    logic [CNT_W-1:0]              r_cnt_q;
    logic signed [SAMPLE_BITS-1:0] r_vb [MAX_DIM];

    // memory port controls
    logic                   cb_we, sum_we, cnt_we;
    logic [AW-1:0]          cb_waddr, cb_raddr, sum_waddr, sum_raddr;
    logic [EW-1:0]          cnt_waddr, cnt_raddr;
    logic [SAMPLE_BITS-1:0] cb_wdata;
    logic [SUM_W-1:0]       sum_wdata;
    logic [CNT_W-1:0]       cnt_wdata;
    logic                   out_load;

    // counters
    logic [DW-1:0] r_i;
    logic [EW-1:0] r_j;
    logic [AW-1:0] r_base;
    logic          r_issue;

    // search pipe
    logic          r_p1_v, r_p2_v, r_p3_v;
    logic [DW-1:0] r_p1_i;
    logic          r_p1_first, r_p2_first, r_p3_first;
    logic          r_p1_last, r_p2_last, r_p3_last;
    logic [EW-1:0] r_p1_j, r_p2_j, r_p3_j;
    logic [AW-1:0] r_p1_base, r_p2_base, r_p3_base;
    logic [SQ_IN_W-1:0]   r_p2_ad;
    logic                 r_p2_big, r_p3_big;
    logic [2*SQ_IN_W-1:0] r_p3_sq;
    logic [ERR_W-1:0]     r_acc, r_best_err;
    logic [EW-1:0]        r_best;
    logic [AW-1:0]        r_best_base;

    // divider
    logic [CNT_W-1:0] r_c;
    logic [DVD_W-1:0] r_dvd;
    logic [CNT_W-1:0] r_rem;
    logic [5:0]       r_dcnt;
    logic             r_neg;

    // output register
    logic             r_ovalid, r_okind;
    logic [7:0]       r_oidx;
    logic [ERR_W-1:0] r_oerr;
    logic [TOT_W-1:0] r_otot;
    logic [1:0]       r_olvl;

    logic [DCW-1:0] dim_u;
    logic [SCW-1:0] size_u;
    logic [DW-1:0]  dim_last;
    logic [EW-1:0]  size_last;
    logic           in_acc, out_free, vec_end, search_done;
    t_op            op_in;

    always_comb begin
        if (r_vdim == 5'd0) begin
            dim_u = DCW'(1);
        end else if (int'(r_vdim) > MAX_DIM) begin
            dim_u = DCW'(MAX_DIM);
        end else begin
            dim_u = DCW'(r_vdim);
        end
        if (r_csize == 9'd0) begin
            size_u = SCW'(1);
        end else if (int'(r_csize) > MAX_ENTRIES) begin
            size_u = SCW'(MAX_ENTRIES);
        end else begin
            size_u = SCW'(r_csize);
        end
    end

    assign dim_last    = DW'(dim_u - DCW'(1));
    assign size_last   = EW'(size_u - SCW'(1));
    assign op_in       = t_op'(i_op);
    assign o_ready     = (r_state == ST_IDLE);
    assign in_acc      = i_valid && o_ready;
    assign out_free    = !r_ovalid || i_ready;
    assign vec_end     = in_acc && (op_in == OP_VECTOR) && !((8'(r_pos) + 8'd1) < 8'(dim_u));
    assign search_done = !r_issue && !r_p1_v && !r_p2_v && !r_p3_v;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:    if (r_clr == AW'(NWORDS - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (in_acc) begin
                    case (op_in)
                        OP_CLEAR:  n_state = ST_CLEAR;
                        OP_UPDATE: n_state = ST_UPD_CNT;
                        OP_VECTOR: if (vec_end) n_state = ST_SEARCH;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SEARCH:   if (search_done) n_state = ST_RESULT;
            ST_RESULT:   if (out_free) n_state = r_train ? ST_TR_CNT : ST_IDLE;
            ST_TR_CNT:   n_state = ST_TR_CHK;
            ST_TR_CHK:   n_state = (r_cnt_q != COUNT_MAX) ? ST_TR_RD : ST_IDLE;
            ST_TR_RD:    n_state = ST_TR_WR;
            ST_TR_WR:    n_state = (r_i == dim_last) ? ST_IDLE : ST_TR_RD;
            ST_UPD_CNT:  n_state = ST_UPD_CHK;
            ST_UPD_CHK:  n_state = (r_cnt_q == '0) ? ST_UPD_NEXT : ST_UPD_RD;
            ST_UPD_RD:   n_state = ST_UPD_LD;
            ST_UPD_LD:   n_state = ST_UPD_DIV;
            ST_UPD_DIV:  if (r_dcnt == 6'd0) n_state = ST_UPD_WR;
            ST_UPD_WR:   n_state = (r_i == dim_last) ? ST_UPD_NEXT : ST_UPD_RD;
            ST_UPD_NEXT: n_state = (r_j == size_last) ? ST_UPD_DONE : ST_UPD_CNT;
            ST_UPD_DONE: if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // ---------------- datapath helpers ----------------
    logic signed [SAMPLE_BITS-1:0] vb_rd;
    logic signed [DIFF_W-1:0]      diff;
    logic [DIFF_W-1:0]             ad;
    logic                          ad_big;
    logic [2*SQ_IN_W:0]            acc_sum;
    logic [ERR_W-1:0]              acc_e;
    logic signed [SUM_W:0]         tr_sum;
    logic [SUM_W-1:0]              tr_sat;
    logic [SUM_W-1:0]              abs_s;
    logic [CNT_W:0]                rem_sh;
    logic                          div_ge;
    logic [SAMPLE_BITS-1:0]        q_sat;
    logic [TOT_W:0]                tot_sum;
    logic [TOT_W-1:0]              tot_new;
    logic [ERR_W-1:0]              thr;
    logic [1:0]                    lvl;

    assign vb_rd = r_vb[(r_state == ST_SEARCH) ? r_p1_i : r_i];

    always_comb begin
        diff   = DIFF_W'(r_cb_q) - DIFF_W'(vb_rd);
        ad     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        ad_big = (33'(ad) >> SQ_IN_W) != 33'd0;

        acc_sum = (2*SQ_IN_W+1)'(r_p3_first ? '0 : r_acc) + (2*SQ_IN_W+1)'(r_p3_sq);
        acc_e   = (r_p3_big || acc_sum[2*SQ_IN_W]) ? ERR_MAX : ERR_W'(acc_sum);

        tr_sum = $signed({r_sum_q[SUM_W-1], r_sum_q}) + (SUM_W+1)'(vb_rd);
        if (tr_sum[SUM_W] != tr_sum[SUM_W-1]) begin
            tr_sat = tr_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            tr_sat = tr_sum[SUM_W-1:0];
        end

        abs_s  = r_sum_q[SUM_W-1] ? (SUM_W'(0) - r_sum_q) : r_sum_q;
        rem_sh = {r_rem, r_dvd[DVD_W-1]};
        div_ge = rem_sh >= {1'b0, r_c};

        if (r_neg) begin
            q_sat = (r_dvd > Q_NEG_MAX) ? SAMPLE_BITS'(Q_NEG_MAX)
                                        : SAMPLE_BITS'(DVD_W'(0) - r_dvd);
        end else begin
            q_sat = (r_dvd > Q_POS_MAX) ? SAMPLE_BITS'(Q_POS_MAX) : SAMPLE_BITS'(r_dvd);
        end

        tot_sum = (TOT_W+1)'(r_total) + (TOT_W+1)'(r_best_err);
        tot_new = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];

        thr = ERR_W'(dim_u) << ONE_SQ_SHIFT;
        lvl = 2'(r_best_err > thr) + 2'(r_best_err > (thr << 2))
            + 2'(r_best_err > ((thr << 3) + thr));
    end

    // ---------------- outputs / memory controls ----------------
    always_comb begin
        cb_we     = 1'b0;
        cb_waddr  = r_base + AW'(r_i);
        cb_wdata  = q_sat;
        cb_raddr  = r_base + AW'(r_i);
        sum_we    = 1'b0;
        sum_waddr = r_best_base + AW'(r_i);
        sum_wdata = tr_sat;
        sum_raddr = (r_state == ST_TR_RD) ? (r_best_base + AW'(r_i)) : (r_base + AW'(r_i));
        cnt_we    = 1'b0;
        cnt_waddr = r_best;
        cnt_wdata = r_cnt_q + CNT_W'(1);
        cnt_raddr = (r_state == ST_TR_CNT) ? r_best : r_j;
        out_load  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                sum_we    = 1'b1;
                sum_waddr = r_clr;
                sum_wdata = '0;
                cnt_we    = (int'(r_clr) < MAX_ENTRIES);
                cnt_waddr = EW'(r_clr);
                cnt_wdata = '0;
            end
            ST_IDLE: begin
                cb_we    = in_acc && (op_in == OP_WRITE) && (int'(i_entry) < MAX_ENTRIES)
                           && (int'(i_element) < MAX_DIM);
                cb_waddr = AW'(int'(i_entry) * MAX_DIM + int'(i_element));
                cb_wdata = i_sample_value;
            end
            ST_RESULT:   out_load = out_free;
            ST_TR_CHK:   cnt_we = (r_cnt_q != COUNT_MAX);
            ST_TR_WR:    sum_we = 1'b1;
            ST_UPD_WR:   cb_we = 1'b1;
            ST_UPD_DONE: out_load = out_free;
            default: begin
            end
        endcase
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (cb_we) r_cb_mem[cb_waddr] <= cb_wdata;
        r_cb_q <= r_cb_mem[cb_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) r_sum_mem[sum_waddr] <= sum_wdata;
        r_sum_q <= r_sum_mem[sum_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) r_cnt_mem[cnt_waddr] <= cnt_wdata;
        r_cnt_q <= r_cnt_mem[cnt_raddr];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_vdim   <= 5'd16;
            r_csize  <= 9'd256;
            r_pos    <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
            r_issue  <= 1'b0;
            r_p1_v   <= 1'b0;
            r_p2_v   <= 1'b0;
            r_p3_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wen) begin
                case (i_cfg_index)
                    CFG_VECTOR_DIM:    r_vdim  <= i_cfg_wdata[4:0];
                    CFG_CODEBOOK_SIZE: r_csize <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            r_clr <= (r_state == ST_CLEAR) ? r_clr + AW'(1) : '0;
            if (in_acc && op_in == OP_VECTOR) begin
                r_pos <= vec_end ? '0 : r_pos + DW'(1);
            end
            if (in_acc && op_in == OP_CLEAR) begin
                r_total <= '0;
            end else if (r_state == ST_RESULT && out_free) begin
                r_total <= tot_new;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (vec_end) begin
                r_issue <= 1'b1;
            end else if (r_issue && r_i == dim_last && r_j == size_last) begin
                r_issue <= 1'b0;
            end
            r_p1_v <= r_issue;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc && op_in == OP_VECTOR) r_vb[r_pos] <= i_sample_value;
        if (vec_end) r_train <= i_train;

        case (r_state)
            ST_IDLE: begin
                r_i    <= '0;
                r_j    <= '0;
                r_base <= '0;
            end
            ST_SEARCH: begin
                if (r_issue) begin
                    if (r_i == dim_last) begin
                        r_i    <= '0;
                        r_j    <= r_j + EW'(1);
                        r_base <= r_base + AW'(MAX_DIM);
                    end else begin
                        r_i <= r_i + DW'(1);
                    end
                end
            end
            ST_RESULT:  r_i <= '0;
            ST_TR_WR:   r_i <= r_i + DW'(1);
            ST_UPD_CHK: begin
                r_i <= '0;
                r_c <= r_cnt_q;
            end
            ST_UPD_LD: begin
                r_neg  <= r_sum_q[SUM_W-1];
                r_dvd  <= DVD_W'(abs_s) + DVD_W'(r_c >> 1);
                r_rem  <= '0;
                r_dcnt <= DIV_LAST;
            end
            ST_UPD_DIV: begin
                r_rem  <= div_ge ? CNT_W'(rem_sh - {1'b0, r_c}) : CNT_W'(rem_sh);
                r_dvd  <= {r_dvd[DVD_W-2:0], div_ge};
                r_dcnt <= r_dcnt - 6'd1;
            end
            ST_UPD_WR:  r_i <= r_i + DW'(1);
            ST_UPD_NEXT: begin
                r_j    <= r_j + EW'(1);
                r_base <= r_base + AW'(MAX_DIM);
            end
            default: begin
            end
        endcase

        // search pipe: tags, |diff|, square, accumulate
        r_p1_i     <= r_i;
        r_p1_first <= (r_i == '0);
        r_p1_last  <= (r_i == dim_last);
        r_p1_j     <= r_j;
        r_p1_base  <= r_base;
        r_p2_ad    <= SQ_IN_W'(ad);
        r_p2_big   <= ad_big;
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_j     <= r_p1_j;
        r_p2_base  <= r_p1_base;
        r_p3_sq    <= r_p2_ad * r_p2_ad;
        r_p3_big   <= r_p2_big;
        r_p3_first <= r_p2_first;
        r_p3_last  <= r_p2_last;
        r_p3_j     <= r_p2_j;
        r_p3_base  <= r_p2_base;
        if (r_p3_v) begin
            r_acc <= acc_e;
            if (r_p3_last && (r_p3_j == '0 || acc_e < r_best_err)) begin
                r_best_err  <= acc_e;
                r_best      <= r_p3_j;
                r_best_base <= r_p3_base;
            end
        end

        if (out_load) begin
            if (r_state == ST_RESULT) begin
                r_okind <= KIND_SEARCH;
                r_oidx  <= 8'(r_best);
                r_oerr  <= r_best_err;
                r_otot  <= tot_new;
                r_olvl  <= lvl;
            end else begin
                r_okind <= KIND_UPDATE;
                r_oidx  <= '0;
                r_oerr  <= '0;
                r_otot  <= '0;
                r_olvl  <= '0;
            end
        end
    end

    assign o_valid         = r_ovalid;
    assign o_result_kind   = r_okind;
    assign o_best_index    = r_oidx;
    assign o_best_error    = r_oerr;
    assign o_total_error   = r_otot;
    assign o_outlier_level = r_olvl;

endmodule

`default_nettype wire

// ===== src/vqlct_checker.sv =====
// ----------------------------------------------------------------------------
// vqlct_port_asserts
// Port-level checks on the result channel of the codebook trainer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vq_lloyd_codebook_trainer_macros.svh"

module vqlct_port_asserts (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_valid,
    input wire logic                          i_ready,
    input wire logic                          o_result_kind,
    input wire logic [7:0]                    o_best_index,
    input wire logic [vqlct_pkg::ERR_W-1:0]   o_best_error,
    input wire logic [vqlct_pkg::TOT_W-1:0]   o_total_error,
    input wire logic [1:0]                    o_outlier_level
);
    import vqlct_pkg::*;

    `VQLCT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `VQLCT_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_best_error) && $stable(o_total_error) && $stable(o_best_index) && $stable(o_result_kind))
    `VQLCT_ASSERT_IMP(a_upd_zero, i_clk, i_rst_n, o_valid && o_result_kind == KIND_UPDATE, o_best_index == 8'd0 && o_best_error == '0 && o_total_error == '0 && o_outlier_level == 2'd0)
    `VQLCT_ASSERT_IMP(a_total_ge, i_clk, i_rst_n, o_valid && o_result_kind == KIND_SEARCH, o_total_error >= TOT_W'(o_best_error))
    `VQLCT_ASSERT_IMP(a_lvl_zero, i_clk, i_rst_n, o_valid && o_best_error == '0, o_outlier_level == 2'd0)

endmodule

bind vq_lloyd_codebook_trainer vqlct_port_asserts u_vqlct_port_asserts (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_result_kind   (o_result_kind),
    .o_best_index    (o_best_index),
    .o_best_error    (o_best_error),
    .o_total_error   (o_total_error),
    .o_outlier_level (o_outlier_level)
);

`default_nettype wire

// ===== verif/vqlct_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqlct_checker
// Watches the item, result and register ports of the codebook trainer, keeps
// its own codebook, centroid and error state, and compares every result item
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module vqlct_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_entry,
    input  logic [3:0]  i_element,
    input  logic signed [15:0] i_sample_value,
    input  logic        i_train,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_result_kind,
    input  logic [7:0]  i_best_index,
    input  logic [35:0] i_best_error,
    input  logic [47:0] i_total_error,
    input  logic [1:0]  i_outlier_level,
    output int          o_failures,
    output int          o_pending
);
    import vqlct_pkg::*;

    localparam int NDIM = 16;
    localparam int NENT = 256;
    localparam longint SMP_MAX = 32767;
    localparam longint SMP_MIN = -32768;
    localparam longint ACC_MAX = 64'sh7F_FFFF_FFFF;
    localparam longint ACC_MIN = -64'sh80_0000_0000;

    typedef struct packed {
        logic        kind;
        logic [7:0]  index;
        logic [35:0] err;
        logic [47:0] total;
        logic [1:0]  level;
    } t_search_result;

    longint          codebook [NENT][NDIM];
    longint          sums     [NENT][NDIM];
    longint unsigned counts   [NENT];
    longint          vec      [NDIM];
    int unsigned     pos;
    longint unsigned err_total;
    logic [4:0]      dim_reg;
    logic [8:0]      size_reg;
    t_search_result  expected_q[$];

    function automatic int unsigned dim_used();
        if (dim_reg == 0) return 1;
        if (dim_reg > NDIM) return NDIM;
        return dim_reg;
    endfunction

    function automatic int unsigned size_used();
        if (size_reg == 0) return 1;
        if (size_reg > NENT) return NENT;
        return size_reg;
    endfunction

    function automatic longint unsigned sq_distance(int unsigned j, int unsigned d);
        longint unsigned e;
        longint diff;
        longint unsigned ad;
        e = 0;
        for (int unsigned i = 0; i < d; i++) begin
            diff = codebook[j][i] - vec[i];
            ad = (diff < 0) ? -diff : diff;
            e += (ad >= (64'd1 << SQ_IN_W)) ? 64'(ERR_MAX) + 1 : ad * ad;
            if (e > ERR_MAX) e = ERR_MAX;
        end
        return e;
    endfunction

    task automatic predict_item();
        int unsigned d, n, best;
        longint unsigned e, beste, thr, c, a, q;
        longint s;
        t_search_result r;
        d = dim_used();
        n = size_used();
        r = '0;
        case (t_op'(i_op))
            OP_WRITE: codebook[i_entry][i_element] = i_sample_value;
            OP_CLEAR: begin
                foreach (sums[j, i]) sums[j][i] = 0;
                foreach (counts[j]) counts[j] = 0;
                err_total = 0;
            end
            OP_UPDATE: begin
                for (int unsigned j = 0; j < n; j++) begin
                    c = counts[j];
                    if (c != 0) begin
                        for (int unsigned i = 0; i < d; i++) begin
                            s = sums[j][i];
                            a = (s < 0) ? -s : s;
                            q = (a + c / 2) / c;
                            s = (sums[j][i] < 0) ? -longint'(q) : longint'(q);
                            if (s > SMP_MAX) s = SMP_MAX;
                            if (s < SMP_MIN) s = SMP_MIN;
                            codebook[j][i] = s;
                        end
                    end
                end
                r.kind = KIND_UPDATE;
                expected_q.push_back(r);
            end
            default: begin
                if (pos < NDIM) vec[pos] = i_sample_value;
                if (pos + 1 < d) begin
                    pos++;
                end else begin
                    pos = 0;
                    best = 0;
                    beste = sq_distance(0, d);
                    for (int unsigned j = 1; j < n; j++) begin
                        e = sq_distance(j, d);
                        if (e < beste) begin
                            beste = e;
                            best = j;
                        end
                    end
                    err_total += beste;
                    if (err_total > TOT_MAX) err_total = TOT_MAX;
                    thr = longint'(d) << ONE_SQ_SHIFT;
                    r.kind  = KIND_SEARCH;
                    r.index = best[7:0];
                    r.err   = beste[35:0];
                    r.total = err_total[47:0];
                    r.level = 2'(beste > thr) + 2'(beste > 4 * thr) + 2'(beste > 9 * thr);
                    expected_q.push_back(r);
                    if (i_train && counts[best] < COUNT_MAX) begin
                        counts[best]++;
                        for (int unsigned i = 0; i < d; i++) begin
                            s = sums[best][i] + vec[i];
                            if (s > ACC_MAX) s = ACC_MAX;
                            if (s < ACC_MIN) s = ACC_MIN;
                            sums[best][i] = s;
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic check_result();
        t_search_result x;
        if (expected_q.size() == 0) begin
            $error("result item with nothing expected");
            o_failures++;
            return;
        end
        x = expected_q.pop_front();
        if (i_result_kind !== x.kind) begin
            $error("result_kind: expected %0d, got %0d", x.kind, i_result_kind);
            o_failures++;
        end
        if (i_best_index !== x.index) begin
            $error("best_index: expected %0d, got %0d", x.index, i_best_index);
            o_failures++;
        end
        if (i_best_error !== x.err) begin
            $error("best_error: expected %0d, got %0d", x.err, i_best_error);
            o_failures++;
        end
        if (i_total_error !== x.total) begin
            $error("total_error: expected %0d, got %0d", x.total, i_total_error);
            o_failures++;
        end
        if (i_outlier_level !== x.level) begin
            $error("outlier_level: expected %0d, got %0d", x.level, i_outlier_level);
            o_failures++;
        end
    endtask

    initial o_failures = 0;
    initial o_pending = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (codebook[j, i]) codebook[j][i] = 0;
            foreach (sums[j, i]) sums[j][i] = 0;
            foreach (counts[j]) counts[j] = 0;
            foreach (vec[i]) vec[i] = 0;
            pos = 0;
            err_total = 0;
            dim_reg = 5'd16;
            size_reg = 9'd256;
            expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result();
            if (i_valid && i_ready_in) predict_item();
            if (i_cfg_wen) begin
                if (i_cfg_index == CFG_VECTOR_DIM) dim_reg = i_cfg_wdata[4:0];
                else size_reg = i_cfg_wdata;
            end
        end
        o_pending = expected_q.size();
    end
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the Lloyd codebook trainer: directed search, train, update
// and clear items, then random phases under several register settings with
// random gaps on both channels. Prediction and checks live in vqlct_checker.
// ----------------------------------------------------------------------------
module tb;
    import vqlct_pkg::*;

    localparam int IDLE_LIMIT = 60000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wen;
    logic        i_cfg_index;
    logic [8:0]  i_cfg_wdata;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_op;
    logic [7:0]  i_entry;
    logic [3:0]  i_element;
    logic signed [15:0] i_sample_value;
    logic        i_train;
    logic        o_valid;
    logic        i_ready;
    logic        o_result_kind;
    logic [7:0]  o_best_index;
    logic [35:0] o_best_error;
    logic [47:0] o_total_error;
    logic [1:0]  o_outlier_level;

    int failures;
    int pending;
    int idle_cycles;
    bit calm;
    bit written [256][16];

    vq_lloyd_codebook_trainer dut (.*);

    vqlct_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .i_ready_in(o_ready), .i_op(i_op), .i_entry(i_entry),
        .i_element(i_element), .i_sample_value(i_sample_value), .i_train(i_train),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_result_kind(o_result_kind),
        .i_best_index(o_best_index), .i_best_error(o_best_error),
        .i_total_error(o_total_error), .i_outlier_level(o_outlier_level),
        .o_failures(failures), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 40) == 0) calm = !calm;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random ready/stall stretches
    int ready_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ready_left <= 0;
            i_ready <= 1'b0;
        end else if (ready_left == 0) begin
            i_ready <= $urandom_range(0, 1);
            ready_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 4);
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(t_op op, logic [7:0] ent, logic [3:0] elem,
                        logic signed [15:0] smp, logic trn);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_entry <= ent;
        i_element <= elem;
        i_sample_value <= smp;
        i_train <= trn;
        if (op == OP_WRITE) written[ent][elem] = 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        // write-back and the accumulator sweep give no item: wait for idle too
        while (pending != 0 || !o_ready) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [8:0] dim, logic [8:0] size);
        i_cfg_wen <= 1'b1;
        i_cfg_index <= CFG_VECTOR_DIM;
        i_cfg_wdata <= dim;
        @(posedge i_clk);
        i_cfg_index <= CFG_CODEBOOK_SIZE;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_sample();
        // small grid values make ties likely
        if ($urandom_range(0, 2) == 0) return 16'($urandom_range(0, 4)) * 16'sd4096 - 16'sd8192;
        return 16'($urandom);
    endfunction

    // every codebook word a search can read must be written first
    task automatic fill_codebook(int dim, int size);
        for (int e = 0; e < size; e++)
            for (int k = 0; k < dim; k++)
                if (!written[e][k]) send(OP_WRITE, 8'(e), 4'(k), rand_sample(), 1'b0);
    endtask

    task automatic random_phase(logic [8:0] dim_w, logic [8:0] size_w, int n);
        int dim, size, r;
        dim = (dim_w[4:0] == 0) ? 1 : (dim_w[4:0] > 16) ? 16 : dim_w[4:0];
        size = (size_w == 0) ? 1 : (size_w > 256) ? 256 : size_w;
        set_regs(dim_w, size_w);
        fill_codebook(dim, size);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 72)
                send(OP_VECTOR, 8'($urandom), 4'($urandom), rand_sample(), 1'($urandom));
            else if (r < 90)
                send(OP_WRITE, 8'($urandom), 4'($urandom), rand_sample(), 1'($urandom));
            else if (r < 95)
                send(OP_UPDATE, 8'($urandom), 4'($urandom), rand_sample(), 1'($urandom));
            else
                send(OP_CLEAR, 8'($urandom), 4'($urandom), rand_sample(), 1'($urandom));
        end
        drain();
    endtask

    initial begin
        int dim;
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_wen = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_op = OP_WRITE;
        i_entry = '0;
        i_element = '0;
        i_sample_value = '0;
        i_train = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: two equal entries (tie), one at the top of the range
        set_regs(9'd2, 9'd3);
        send(OP_WRITE, 0, 0, 0, 0);
        send(OP_WRITE, 0, 1, 0, 0);
        send(OP_WRITE, 1, 0, 0, 0);
        send(OP_WRITE, 1, 1, 0, 0);
        send(OP_WRITE, 2, 0, 16'sh7FFF, 0);
        send(OP_WRITE, 2, 1, 16'sh7FFF, 0);
        send(OP_VECTOR, 0, 0, 0, 1);            // tie, zero error
        send(OP_VECTOR, 0, 0, 0, 1);
        send(OP_VECTOR, 0, 0, -16'sh8000, 1);   // level 3
        send(OP_VECTOR, 0, 0, -16'sh8000, 1);
        send(OP_VECTOR, 0, 0, 16'sd6144, 0);    // level 1
        send(OP_VECTOR, 0, 0, 16'sd6144, 0);
        send(OP_VECTOR, 0, 0, -16'sd10240, 1);  // level 2
        send(OP_VECTOR, 0, 0, -16'sd10240, 1);
        send(OP_VECTOR, 0, 0, 16'sh7FFF, 1);
        send(OP_VECTOR, 0, 0, 16'sh7FFF, 1);
        send(OP_UPDATE, 0, 0, 0, 0);
        send(OP_VECTOR, 0, 0, 16'sd100, 0);
        send(OP_VECTOR, 0, 0, -16'sd100, 0);
        send(OP_CLEAR, 0, 0, 0, 0);
        send(OP_UPDATE, 0, 0, 0, 0);            // no counts: codebook kept
        send(OP_VECTOR, 0, 0, 16'sd1, 1);       // half a vector left in flight
        drain();

        // register extremes, including zero and out-of-range values
        random_phase(9'd1, 9'd256, 40);
        random_phase(9'd16, 9'd1, 40);
        random_phase(9'd0, 9'd0, 30);
        random_phase(9'd31, 9'd2, 40);
        random_phase(9'd0, 9'd511, 40);
        for (int p = 0; p < 8; p++) begin
            dim = $urandom_range(1, 16);
            random_phase(9'(dim), 9'($urandom_range(1, (64 / dim) + 1)), 30);
        end

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (5000) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
